// File: src/bcg_pkg.sv
`default_nettype none
package bcg_pkg;

    // Field and register widths
    localparam int TIME_W     = 48;
    localparam int MV_W       = 13;
    localparam int FRAC_W     = 8;
    localparam int SMOOTH_W   = MV_W + FRAC_W;
    localparam int PCT_W      = 7;
    localparam int SHIFT_W    = 3;
    localparam int INTERVAL_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Average update needs room for smoothed << shift plus the new sample
    localparam int SUM_W = SMOOTH_W + 2 ** SHIFT_W;
    // Rounded voltage used for the curve lookup
    localparam int AVG_W = MV_W + 1;

    // Charge curve
    localparam int CURVE_POINTS = 15;
    localparam int IDX_W        = $clog2(CURVE_POINTS);

    // Interpolation divider: numerator is (offset * rise)
    localparam int NUM_W = MV_W + PCT_W;
    localparam int CNT_W = $clog2(NUM_W);

    // Reset values of the configuration registers
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(5000000);
    localparam logic [SHIFT_W-1:0]    SHIFT_RST    = SHIFT_W'(2);

    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_SHIFT = CFG_IDX_W'(1);

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4180, 13'd4100, 13'd4030, 13'd3970, 13'd3920, 13'd3870, 13'd3830, 13'd3800,
        13'd3775, 13'd3750, 13'd3720, 13'd3690, 13'd3640, 13'd3500, 13'd3300
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd92, 7'd85, 7'd77, 7'd69, 7'd60, 7'd50, 7'd40,
        7'd30, 7'd22, 7'd15, 7'd10, 7'd5, 7'd2, 7'd0
    };

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the incoming poll
        logic eval;      // gate the poll, reschedule, update the average
        logic map;       // pick the curve segment and load the divider
        logic div_step;  // one restoring-divide step
        logic finish;    // form the percentage and apply the change filter
        logic emit;      // move the pending result into the output register
    } t_bcg_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip;      // poll is ignored
        logic fail;      // reading failed
        logic div_last;  // final divide step in progress
        logic show;      // percentage must be reported
        logic out_free;  // output register can take a result
    } t_bcg_sts;

    // Segment search: smallest i >= 1 with mv >= CURVE_MV[i]
    function automatic logic [IDX_W-1:0] seg_index(input logic [AVG_W-1:0] mv);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(1);
        for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
            if (mv >= AVG_W'(CURVE_MV[i])) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// File: src/bcg_in_if.sv
`default_nettype none
interface bcg_in_if import bcg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_us;
    logic              busy_req;
    logic [MV_W-1:0]   reading_mv;

    modport source (output valid, output now_us, output busy_req, output reading_mv,
                    input ready);
    modport sink   (input valid, input now_us, input busy_req, input reading_mv,
                    output ready);
endinterface
`default_nettype wire

// File: src/bcg_out_if.sv
`default_nettype none
interface bcg_out_if import bcg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             pct_known;
    logic [PCT_W-1:0] pct;

    modport source (output valid, output pct_known, output pct, input ready);
    modport sink   (input valid, input pct_known, input pct, output ready);
endinterface
`default_nettype wire

// File: src/bcg_ctrl.sv
`default_nettype none
module bcg_ctrl import bcg_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_bcg_sts i_sts,
    output t_bcg_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MAP  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DONE = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else if (i_sts.fail) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = i_sts.show ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/bcg_dp.sv
`default_nettype none
module bcg_dp import bcg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_bcg_cmd              i_cmd,
    output t_bcg_sts                   o_sts,
    input  wire logic [TIME_W-1:0]     i_now_us,
    input  wire logic                  i_busy_req,
    input  wire logic [MV_W-1:0]       i_reading_mv,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_pct_known,
    output logic [PCT_W-1:0]           o_pct
);

    // configuration
    logic [INTERVAL_W-1:0] r_interval;
    logic [SHIFT_W-1:0]    r_shift;

    // block state
    logic [TIME_W-1:0]   r_next;
    logic [SMOOTH_W-1:0] r_smooth;
    logic [PCT_W-1:0]    r_shown;
    logic                r_shown_valid;

    // captured poll
    logic [TIME_W-1:0] r_now;
    logic              r_busy;
    logic [MV_W-1:0]   r_mv;

    // interpolation and divider
    logic [PCT_W-1:0] r_base;
    logic [NUM_W-1:0] r_num;
    logic [MV_W-1:0]  r_den;
    logic [MV_W-1:0]  r_rem;
    logic [CNT_W-1:0] r_cnt;

    // pending result and output register
    logic             r_res_known;
    logic [PCT_W-1:0] r_res_pct;
    logic             r_out_valid;
    logic             r_out_known;
    logic [PCT_W-1:0] r_out_pct;

    logic [TIME_W:0]     w_next_sum;
    logic [TIME_W-1:0]   w_next;
    logic [SMOOTH_W-1:0] w_x;
    logic [SUM_W-1:0]    w_half;
    logic [SUM_W-1:0]    w_sum;
    logic [SMOOTH_W-1:0] w_smooth_new;
    logic [AVG_W-1:0]    w_avg;
    logic [IDX_W-1:0]    w_idx;
    logic [MV_W-1:0]     w_mv_hi;
    logic [MV_W-1:0]     w_mv_lo;
    logic [PCT_W-1:0]    w_pct_hi;
    logic [PCT_W-1:0]    w_pct_lo;
    logic [MV_W-1:0]     w_span;
    logic [PCT_W-1:0]    w_rise;
    logic [MV_W-1:0]     w_off;
    logic                w_flat;
    logic [MV_W:0]       w_rem_sh;
    logic                w_qbit;
    logic [PCT_W:0]      w_pct_sum;
    logic [PCT_W-1:0]    w_pct;

    always_comb begin
        // schedule: now + interval, saturating
        w_next_sum = {1'b0, r_now} + (TIME_W + 1)'(r_interval);
        w_next     = w_next_sum[TIME_W] ? '1 : w_next_sum[TIME_W-1:0];

        // average: (s*(2^k-1) + x + half) >> k
        w_x          = {r_mv, FRAC_W'(0)};
        w_half       = (r_shift == '0) ? '0 : (SUM_W'(1) << (r_shift - SHIFT_W'(1)));
        w_sum        = (SUM_W'(r_smooth) << r_shift) - SUM_W'(r_smooth)
                     + SUM_W'(w_x) + w_half;
        w_smooth_new = (r_smooth == '0) ? w_x : SMOOTH_W'(w_sum >> r_shift);

        // rounded voltage and curve segment
        w_avg    = AVG_W'((SUM_W'(r_smooth) + SUM_W'(1 << (FRAC_W - 1))) >> FRAC_W);
        w_idx    = seg_index(w_avg);
        w_mv_hi  = CURVE_MV[w_idx - IDX_W'(1)];
        w_mv_lo  = CURVE_MV[w_idx];
        w_pct_hi = CURVE_PCT[w_idx - IDX_W'(1)];
        w_pct_lo = CURVE_PCT[w_idx];
        w_span   = w_mv_hi - w_mv_lo;
        w_rise   = w_pct_hi - w_pct_lo;
        w_off    = MV_W'(w_avg - AVG_W'(w_mv_lo));
        w_flat   = (w_span == '0) || (w_mv_hi < w_mv_lo) || (w_pct_hi < w_pct_lo);

        // one restoring-divide step
        w_rem_sh = {r_rem, r_num[NUM_W-1]};
        w_qbit   = (w_rem_sh >= {1'b0, r_den});

        // final percentage and change filter
        w_pct_sum = {1'b0, r_base} + {1'b0, r_num[PCT_W-1:0]};
        w_pct     = w_pct_sum[PCT_W-1:0];

        o_sts.skip     = (r_now < r_next) || (r_busy && (r_smooth != '0));
        o_sts.fail     = (r_mv == '0);
        o_sts.div_last = (r_cnt == CNT_W'(NUM_W - 1));
        o_sts.show     = !r_shown_valid
                       || ({1'b0, w_pct} > ({1'b0, r_shown} + (PCT_W + 1)'(1)))
                       || (({1'b0, w_pct} + (PCT_W + 1)'(1)) < {1'b0, r_shown})
                       || (w_pct == PCT_FULL) || (w_pct == PCT_EMPTY);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= INTERVAL_RST;
            r_shift       <= SHIFT_RST;
            r_next        <= '0;
            r_smooth      <= '0;
            r_shown       <= '0;
            r_shown_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                    CFG_SMOOTHING_SHIFT: r_shift    <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.eval && !o_sts.skip) begin
                r_next <= w_next;
                if (!o_sts.fail) begin
                    r_smooth <= w_smooth_new;
                end
            end
            if (i_cmd.finish && o_sts.show) begin
                r_shown       <= w_pct;
                r_shown_valid <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_now  <= i_now_us;
            r_busy <= i_busy_req;
            r_mv   <= i_reading_mv;
        end
        if (i_cmd.eval) begin
            r_res_known <= 1'b0;
            r_res_pct   <= '0;
        end
        if (i_cmd.map) begin
            r_rem <= '0;
            r_cnt <= '0;
            if (w_avg >= AVG_W'(CURVE_MV[0])) begin
                r_base <= PCT_FULL;
                r_num  <= '0;
                r_den  <= MV_W'(1);
            end else if (w_avg <= AVG_W'(CURVE_MV[CURVE_POINTS-1])) begin
                r_base <= PCT_EMPTY;
                r_num  <= '0;
                r_den  <= MV_W'(1);
            end else if (w_flat) begin
                r_base <= w_pct_lo;
                r_num  <= '0;
                r_den  <= MV_W'(1);
            end else begin
                r_base <= w_pct_lo;
                r_num  <= NUM_W'(w_off * w_rise);
                r_den  <= w_span;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? MV_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[MV_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_qbit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_res_known <= 1'b1;
            r_res_pct   <= w_pct;
        end
        if (i_cmd.emit) begin
            r_out_known <= r_res_known;
            r_out_pct   <= r_res_pct;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pct_known = r_out_known;
    assign o_pct       = r_out_pct;

endmodule
`default_nettype wire

// File: src/battery_charge_gauge.sv
`default_nettype none
// Battery charge gauge. Each poll transaction on i_in carries a time stamp in
// microseconds, a busy flag and a voltage reading in mV. A poll that arrives before
// the scheduled sample time, or while busy once an average exists, is dropped
// with no result. Otherwise the next sample is scheduled interval microseconds
// later (saturating), and one result may follow: a failed (0 mV) reading gives
// pct_known = 0, pct = 0; a good reading updates a rounded exponential average
// (8 fraction bits, gain 1/2^smoothing_shift), maps it through a 15-point
// charge curve, and reports the percentage only when none has been shown yet,
// when it moves by 2 or more, or when it hits 0 or 100. The curve
// interpolation uses a 20-step restoring divider. The input is held off while
// a poll is in work; a finished result sits in the output register while the
// next poll is already taken. Configuration writes (index 0 sample interval,
// index 1 smoothing shift) must be made only while idle; the block itself
// does not enforce this.
module battery_charge_gauge import bcg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bcg_in_if.sink                     i_in,
    bcg_out_if.source                  o_out
);

    t_bcg_cmd w_cmd;
    t_bcg_sts w_sts;

    // sequence one poll at a time
    bcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // schedule, average, curve mapping, divider and output register
    bcg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_now_us     (i_in.now_us),
        .i_busy_req   (i_in.busy_req),
        .i_reading_mv (i_in.reading_mv),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_pct_known  (o_out.pct_known),
        .o_pct        (o_out.pct)
    );

endmodule
`default_nettype wire
